FILE: rtl/m4vt_pkg.sv
// m4vt_pkg: shared types, constants and helpers for the 4x4 matrix-vector transform core
// no dependencies
package m4vt_pkg;

  localparam int Dim      = 4;
  localparam int Stride   = 4;
  localparam int Elems    = 16;
  localparam int FracBits = 16;

  typedef logic signed [31:0] word_t;
  typedef logic signed [63:0] prod_t;
  // a shifted product needs 48 bits, four of them summed need 50
  typedef logic signed [49:0] acc_t;

  typedef enum logic [1:0] {
    KIND_WRITE_MAIN    = 2'd0,
    KIND_WRITE_OPERAND = 2'd1,
    KIND_COMPOSE       = 2'd2,
    KIND_TRANSFORM     = 2'd3
  } kind_e;

  function automatic word_t sat32(input acc_t s);
    if (s > 50'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -50'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return s[31:0];
    end
  endfunction

endpackage

FILE: rtl/m4vt_lane.sv
// m4vt_lane: one row lane, multiplies four pairs and floors each product
// depends on m4vt_pkg
module m4vt_lane (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  m4vt_pkg::word_t [3:0] a_i,
  input  m4vt_pkg::word_t [3:0] b_i,
  output m4vt_pkg::acc_t        sum_o
);

  m4vt_pkg::prod_t [3:0] prod_q;
  m4vt_pkg::acc_t        acc;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= 64'(a_i[k]) * 64'(b_i[k]);
      end
    end
  end

  // arithmetic shift floors toward minus infinity; lanes above Dim contribute zero
  always_comb begin
    acc = '0;
    for (int k = 0; k < m4vt_pkg::Dim; k++) begin
      acc = acc + m4vt_pkg::acc_t'(prod_q[k] >>> m4vt_pkg::FracBits);
    end
  end

  assign sum_o = acc;

endmodule

FILE: rtl/m4vt_merge.sv
// m4vt_merge: saturates the lane sums and holds the result item
// depends on m4vt_pkg
module m4vt_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  m4vt_pkg::acc_t [3:0]       sum_i,
  input  logic                       tready_i,
  output logic                       tvalid_o,
  output m4vt_pkg::word_t [3:0]      res_o,
  output m4vt_pkg::word_t [3:0]      sat_o
);

  logic                   vld_q;
  m4vt_pkg::word_t [3:0]  res_q;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sat_o[r] = (r < m4vt_pkg::Dim) ? m4vt_pkg::sat32(sum_i[r]) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (vld_i) begin
      vld_q <= 1'b1;
    end else if (tready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) res_q <= sat_o;
  end

  assign tvalid_o = vld_q;
  assign res_o    = res_q;

endmodule

FILE: rtl/mat4_vertex_transform_core.sv
// mat4_vertex_transform_core: top level, matrix store, sequencer, four row lanes
// depends on m4vt_pkg, m4vt_lane, m4vt_merge
//
// channel  | dir | fields
// s_axis   | in  | tuser: kind; tdata: elem_index, elem_value, vec_x..vec_w
// m_axis   | out | tdata: out_x, out_y, out_z, out_w
//
// transform: products registered at the accepting edge, then in ST_SUM the sum and
// saturation load the output register, which raises tvalid
// compose: four passes through the lanes (one result column each), each ST_MUL then ST_SUM
// writes: stored at the accepting edge; reset clears both matrices and all control at once
// input stalls while an item is in flight or a result waits to be taken
module mat4_vertex_transform_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,   // kind
  input  logic [167:0] s_axis_tdata,   // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // out_x, out_y, out_z, out_w
);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SUM} state_e;

  state_e                state_q;
  logic                  xform_q;      // current pass is a transform
  logic [2:0]            col_q;        // compose column, 0 to 3
  m4vt_pkg::word_t [15:0] main_q, opnd_q;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  logic [3:0]      in_idx;
  m4vt_pkg::word_t in_val;
  assign in_idx = s_axis_tdata[3:0];
  assign in_val = s_axis_tdata[35:4];

  // lanes: lane r takes row r of main against the vector or an operand column
  m4vt_pkg::word_t [3:0][3:0] lane_a, lane_b;
  m4vt_pkg::acc_t  [3:0]      lane_sum;
  m4vt_pkg::word_t [3:0]      sat;
  logic                       lane_en;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 4; k++) begin
        lane_a[r][k] = main_q[k*m4vt_pkg::Stride + r];
        if (state_q == ST_IDLE) begin
          lane_b[r][k] = s_axis_tdata[36 + 32*k +: 32];
        end else begin
          lane_b[r][k] = opnd_q[col_q[1:0]*m4vt_pkg::Stride + k];
        end
      end
    end
  end

  assign lane_en = (accept && s_axis_tuser == m4vt_pkg::KIND_TRANSFORM)
                || (state_q == ST_MUL && !xform_q);

  for (genvar r = 0; r < 4; r++) begin : g_lane
    m4vt_lane u_lane (
      .clk_i (clk_i),
      .en_i  (lane_en),
      .a_i   (lane_a[r]),
      .b_i   (lane_b[r]),
      .sum_o (lane_sum[r])
    );
  end

  logic out_load;
  assign out_load = (state_q == ST_SUM) && xform_q;

  m4vt_pkg::word_t [3:0] res;
  m4vt_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (out_load),
    .sum_i    (lane_sum),
    .tready_i (m_axis_tready),
    .tvalid_o (m_axis_tvalid),
    .res_o    (res),
    .sat_o    (sat)
  );

  assign m_axis_tdata  = {res[3], res[2], res[1], res[0]};
  assign s_axis_tready = (state_q == ST_IDLE) && !m_axis_tvalid;

  // compose results wait in a column buffer so all columns read the old main
  m4vt_pkg::word_t [15:0] next_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      xform_q <= 1'b0;
      col_q   <= '0;
      main_q  <= '0;
      opnd_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (m4vt_pkg::kind_e'(s_axis_tuser))
              m4vt_pkg::KIND_WRITE_MAIN:    main_q[in_idx] <= in_val;
              m4vt_pkg::KIND_WRITE_OPERAND: opnd_q[in_idx] <= in_val;
              m4vt_pkg::KIND_COMPOSE: begin
                xform_q <= 1'b0;
                col_q   <= '0;
                state_q <= ST_MUL;
              end
              m4vt_pkg::KIND_TRANSFORM: begin
                xform_q <= 1'b1;
                state_q <= ST_SUM;
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          if (xform_q) begin
            state_q <= ST_IDLE;
          end else if (col_q == 3'd3) begin
            // columns at or above Dim keep old values
            for (int c = 0; c < 4; c++) begin
              for (int r = 0; r < 4; r++) begin
                if (c < m4vt_pkg::Dim && r < m4vt_pkg::Dim) begin
                  main_q[c*4 + r] <= (c == 3) ? sat[r] : next_q[c*4 + r];
                end
              end
            end
            state_q <= ST_IDLE;
          end else begin
            col_q   <= col_q + 3'd1;
            state_q <= ST_MUL;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM && !xform_q) begin
      for (int r = 0; r < 4; r++) begin
        next_q[col_q[1:0]*4 + r] <= sat[r];
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !s_axis_tready) else $error("accept while busy");
  a_xform_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM && xform_q) |=> m_axis_tvalid) else $error("transform lost");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < 3'd4) else $error("column out of range");

endmodule
